>>> design/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types, constants and helpers of the ADPCM frame decoder.
// ----------------------------------------------------------------------------
package afd_pkg;

	localparam int DEF_MAX_ORDER = 8;
	localparam int DEF_MAX_PREDICTORS = 16;

	localparam int COEF_W = 16;
	localparam int HIST_W = 32;
	localparam int RES_W = 19;
	localparam int PROD_W = COEF_W + HIST_W;
	localparam int ACC_W = PROD_W + 4;
	localparam int SUM_W = ACC_W + 1;
	localparam int FRAC_BITS = 11;

	localparam logic [1:0] ACT_COEF = 2'd0;
	localparam logic [1:0] ACT_HIST = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_PRED = 2'd1;
	localparam logic [1:0] ERR_OVF = 2'd2;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_RESID,
		ST_DRAIN,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic load;
		logic err_pred;
		logic tail;
		logic final_run;
	} emit_t;

	function automatic logic signed [RES_W-1:0] resid_of(input logic [63:0] payload,
			input logic [3:0] idx, input logic [3:0] scale);
		logic [3:0] nib;
		logic signed [RES_W-1:0] ext;
		nib = 4'(payload >> (6'd60 - {idx, 2'b00}));
		ext = RES_W'(signed'(nib));
		return ext <<< scale;
	endfunction

endpackage

>>> design/adpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// adpcm_frame_decoder
// Predictive ADPCM decoder: up to sixteen saturated samples per nine-byte frame.
// ----------------------------------------------------------------------------
// Each half-frame streams order*8 codebook words from the codebook memory,
// one per cycle, into eight lanes, then passes a wait state, 7 residual steps,
// a drain state and 8 output steps, which wait while the output is stalled.
// The input is not ready again until the last sample of the frame is loaded.
// Load items are taken only while idle. Reset clears the history, the control state and the
// registers to order 2 and one predictor; the codebook is undefined until written.
module adpcm_frame_decoder
	import afd_pkg::*;
#(
	parameter int MAX_ORDER = DEF_MAX_ORDER,
	parameter int MAX_PREDICTORS = DEF_MAX_PREDICTORS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [9:0]         table_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [31:0] history_value,
	input  logic [7:0]         frame_header,
	input  logic [63:0]        frame_payload,
	input  logic               final_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pcm_sample,
	output logic               sample_last,
	output logic               run_done,
	output logic [1:0]         error_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int CW = $clog2(MAX_ORDER * 8);

	state_t st_q, st_d;
	logic [3:0] ord_q;
	logic [4:0] cnt_q;
	logic [3:0] ord_eff, ordm1;
	logic [4:0] cnt_eff;

	logic signed [COEF_W-1:0] cb_mem [1024];
	logic signed [COEF_W-1:0] rdata_q;
	logic signed [HIST_W-1:0] hist_q [16];

	logic [9:0] base_q;
	logic [63:0] payload_q;
	logic [3:0] scale_q;
	logic final_q;
	logic h_q;
	logic [CW-1:0] c_q;
	logic [2:0] k_q;

	logic fv_s1;
	logic [2:0] i_s1;
	logic [3:0] j_s1;
	logic signed [HIST_W-1:0] tap_s1;

	logic signed [COEF_W-1:0] row_q [8];

	logic in_xfer, start, fetch_v, resid_en, last_c;
	emit_t em;
	logic ovf, slot_free;
	logic signed [HIST_W-1:0] hword;
	logic [3:0] hidx;
	logic signed [RES_W-1:0] resid_cur, resid_out;
	logic signed [ACC_W-1:0] acc [8];
	logic [7:0] lane_en;
	logic signed [COEF_W-1:0] lane_coef [8];
	logic signed [HIST_W-1:0] lane_opnd;

	assign ord_eff = (ord_q == 4'd0) ? 4'd1 :
		(ord_q > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : ord_q;
	assign ordm1 = ord_eff - 4'd1;
	assign cnt_eff = (cnt_q > 5'(MAX_PREDICTORS)) ? 5'(MAX_PREDICTORS) : cnt_q;

	assign in_xfer = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign last_c = (c_q[2:0] == 3'd7) && (4'(c_q >> 3) == ordm1);
	assign hidx = {h_q, 3'b000} - ord_eff + 4'(c_q >> 3);

	always_comb begin
		st_d = st_q;
		in_ready = 1'b0;
		start = 1'b0;
		fetch_v = 1'b0;
		resid_en = 1'b0;
		em = '0;
		em.tail = h_q && (k_q == 3'd7);
		em.final_run = final_q;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer && action == ACT_DECODE) begin
					if ({1'b0, frame_header[3:0]} >= cnt_eff) begin
						st_d = ST_ERR;
					end else begin
						st_d = ST_FETCH;
						start = 1'b1;
					end
				end
			end
			ST_FETCH: begin
				fetch_v = 1'b1;
				if (last_c) st_d = ST_WAIT;
			end
			ST_WAIT: st_d = ST_RESID;
			ST_RESID: begin
				resid_en = 1'b1;
				if (k_q == 3'd6) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (k_q == 3'd2) st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					em.load = 1'b1;
					if (ovf) begin
						st_d = ST_IDLE;
					end else if (k_q == 3'd7) begin
						if (h_q) begin
							st_d = ST_IDLE;
						end else begin
							st_d = ST_FETCH;
							start = 1'b1;
						end
					end
				end
			end
			ST_ERR: begin
				em.err_pred = 1'b1;
				if (slot_free) begin
					em.load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q <= 4'd2;
			cnt_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ORDER) ord_q <= cfg_data[3:0];
			else if (cfg_index == REG_COUNT) cnt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			k_q <= '0;
			h_q <= 1'b0;
			fv_s1 <= 1'b0;
		end else begin
			fv_s1 <= fetch_v;
			c_q <= (st_q == ST_FETCH && !last_c) ? c_q + CW'(1) : '0;
			if (st_d != st_q) begin
				k_q <= '0;
			end else if (st_q != ST_EMIT || em.load) begin
				k_q <= k_q + 3'd1;
			end
			if (st_q == ST_IDLE) begin
				h_q <= 1'b0;
			end else if (start) begin
				h_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && action == ACT_DECODE) begin
			base_q <= 10'({8'(frame_header[3:0]) * 8'(ord_eff), 3'b000});
			payload_q <= frame_payload;
			scale_q <= frame_header[7:4];
			final_q <= final_frame;
		end
		i_s1 <= c_q[2:0];
		j_s1 <= 4'(c_q >> 3);
		tap_s1 <= hist_q[hidx];
	end

	always_ff @(posedge clk) begin
		if (in_xfer && action == ACT_COEF) begin
			cb_mem[table_index] <= coef_value;
		end
		rdata_q <= cb_mem[base_q + 10'(c_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 16; n++) hist_q[n] <= '0;
		end else if (in_xfer && action == ACT_HIST && table_index < 10'd16) begin
			hist_q[table_index[3:0]] <= history_value;
		end else if (em.load && !em.err_pred && !ovf) begin
			hist_q[{h_q, k_q}] <= hword;
		end
	end

	always_ff @(posedge clk) begin
		row_q[0] <= '0;
		for (int n = 1; n < 8; n++) begin
			if (resid_en) begin
				row_q[n] <= row_q[n-1];
			end else if (fv_s1 && j_s1 == ordm1 && i_s1 == 3'(n - 1)) begin
				row_q[n] <= rdata_q;
			end
		end
	end

	assign resid_cur = resid_of(payload_q, {h_q, k_q}, scale_q);
	assign resid_out = resid_of(payload_q, {h_q, k_q}, scale_q);
	assign lane_opnd = resid_en ? HIST_W'(resid_cur) : tap_s1;

	for (genvar g = 0; g < 8; g++) begin : g_lane
		assign lane_en[g] = resid_en || (fv_s1 && i_s1 == 3'(g));
		assign lane_coef[g] = resid_en ? row_q[g] : rdata_q;
		afd_lane u_lane (
			.clk  (clk),
			.arst_n(arst_n),
			.clr  (start),
			.en   (lane_en[g]),
			.coef (lane_coef[g]),
			.opnd (lane_opnd),
			.acc  (acc[g])
		);
	end

	afd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.em         (em),
		.acc        (acc[k_q]),
		.resid      (resid_out),
		.ovf        (ovf),
		.hword      (hword),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pcm_sample (pcm_sample),
		.sample_last(sample_last),
		.run_done   (run_done),
		.error_code (error_code)
	);

endmodule

>>> design/afd_lane.sv
// ----------------------------------------------------------------------------
// afd_lane
// One output lane: registered multiply followed by an accumulator.
// ----------------------------------------------------------------------------
module afd_lane
	import afd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     en,
	input  logic signed [COEF_W-1:0] coef,
	input  logic signed [HIST_W-1:0] opnd,
	output logic signed [ACC_W-1:0]  acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic en_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= en && !clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(coef * opnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

>>> design/afd_merge.sv
// ----------------------------------------------------------------------------
// afd_merge
// Scales a lane sum, adds the residual, checks range and holds the result.
// ----------------------------------------------------------------------------
module afd_merge
	import afd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  emit_t                    em,
	input  logic signed [ACC_W-1:0]  acc,
	input  logic signed [RES_W-1:0]  resid,
	output logic                     ovf,
	output logic signed [HIST_W-1:0] hword,
	output logic                     slot_free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [15:0]       pcm_sample,
	output logic                     sample_last,
	output logic                     run_done,
	output logic [1:0]               error_code
);

	logic signed [SUM_W-1:0] v;
	logic signed [15:0] sat;
	logic last;
	logic valid_q;

	assign v = SUM_W'(acc >>> FRAC_BITS) + SUM_W'(resid);
	assign ovf = !em.err_pred && (v > SUM_W'(32'sh7FFFFFFF) || v < -SUM_W'(64'sh80000000));
	assign hword = HIST_W'(v);
	assign sat = (v > SUM_W'(32767)) ? 16'sh7FFF :
		(v < SUM_W'(-32768)) ? 16'sh8000 : 16'(v);
	assign last = em.err_pred || ovf || em.tail;
	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (em.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em.load) begin
			pcm_sample <= (em.err_pred || ovf) ? 16'sd0 : sat;
			sample_last <= last;
			run_done <= last && em.final_run;
			error_code <= em.err_pred ? ERR_PRED : (ovf ? ERR_OVF : ERR_NONE);
		end
	end

	assign out_valid = valid_q;

endmodule

>>> design/afd_checker.sv
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks of the ADPCM frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module afd_checker
	import afd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] pcm_sample,
	input logic               sample_last,
	input logic               run_done,
	input logic [1:0]         error_code
);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_done |-> sample_last)
		else $error("run_done without sample_last");

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> sample_last && pcm_sample == 16'sd0)
		else $error("error result not a zero final sample");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pcm_sample)
			&& $stable(sample_last) && $stable(error_code))
		else $error("stalled result changed");

	a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_last && !out_ready |-> !in_ready)
		else $error("input taken while a frame is in progress");

endmodule

bind adpcm_frame_decoder afd_checker u_afd_checker (.*);
